// ----- rtl/aard_pkg.sv -----
// ----------------------------------------------------------------------------
// aard_pkg
// Shared field widths and register codes of the row downscaler.
// ----------------------------------------------------------------------------
package aard_pkg;

    // Pixel component width, on both sides.
    localparam int PIX_BITS      = 8;
    // Output position and source row fields.
    localparam int POS_BITS      = 12;
    localparam int SRC_ROW_BITS  = 16;

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 56;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic [CFG_INDEX_BITS-1:0] REG_OLD_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEW_WIDTH = 1'b1;

endpackage

// ----- rtl/aard_queue.sv -----
// ----------------------------------------------------------------------------
// aard_queue
// Two-entry queue that carries finished output jobs from the front end to
// the divider back end.
// ----------------------------------------------------------------------------
module aard_queue #(
    parameter int DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DATA_BITS-1:0] in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_BITS-1:0] out_data
);

    localparam int DEPTH     = 2;
    localparam int PTR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] entry_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != CNT_BITS'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- rtl/aard_front.sv -----
// ----------------------------------------------------------------------------
// aard_front
// Accepts source pixels, weights them by their overlap with the open output
// pixel and hands each completed output to the queue as a job.
// ----------------------------------------------------------------------------
module aard_front #(
    parameter int WIDTH_BITS = 12,
    parameter int ROW_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [aard_pkg::CFG_DATA_BITS-1:0]    old_width,
    input  logic [aard_pkg::CFG_DATA_BITS-1:0]    dst_width,
    input  logic                                  pix_valid,
    output logic                                  pix_ready,
    input  logic [aard_pkg::IN_DATA_BITS-1:0]     pix_data,
    input  logic                                  pix_start,
    output logic                                  job_valid,
    input  logic                                  job_ready,
    output logic [3*(WIDTH_BITS+8)+WIDTH_BITS+1+aard_pkg::POS_BITS+aard_pkg::SRC_ROW_BITS:0]
                                                  job_data
);

    localparam int PB = aard_pkg::PIX_BITS;
    localparam int WW = WIDTH_BITS + 1;
    localparam int SW = WIDTH_BITS + 8;
    localparam int PW = WW + PB;
    localparam int CW = (WW > aard_pkg::CFG_DATA_BITS) ? WW : aard_pkg::CFG_DATA_BITS;
    localparam logic [CW-1:0] MAX_W = CW'(1) << WIDTH_BITS;

    logic [SW-1:0]         sum_reg [3];
    logic [SW-1:0]         sum_next [3];
    logic [WW-1:0]         units_reg, units_next;
    logic [WIDTH_BITS-1:0] in_col_reg, in_col_next;
    logic [WIDTH_BITS-1:0] out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;

    logic [CW-1:0]         old_ext, new_ext, w_ext, n_ext;
    logic [WW-1:0]         w, n, rem, take, spill;
    logic [SW-1:0]         cur_sum [3];
    logic [WW-1:0]         cur_units;
    logic [WIDTH_BITS-1:0] cur_in, cur_out;
    logic [ROW_BITS-1:0]   cur_row;
    logic                  last, accumulate, accept;
    logic [PB-1:0]         pix [3];
    logic [PW-1:0]         prod_n [3];
    logic [PW-1:0]         prod_take [3];
    logic [SW:0]           acc_sum [3];
    logic [SW-1:0]         sat_sum [3];
    logic [SW-1:0]         spill_prod [3];
    logic [WIDTH_BITS+aard_pkg::POS_BITS-1:0]   pos_wide;
    logic [ROW_BITS+aard_pkg::SRC_ROW_BITS-1:0] row_wide;

    assign pix_ready = job_ready;
    assign accept    = pix_valid && pix_ready;
    assign job_valid = pix_valid && !accumulate;

    always_comb
    begin
        // Effective widths: zero acts as one, old width saturates at the
        // column range, new width never exceeds old width.
        old_ext = CW'(old_width);
        new_ext = CW'(dst_width);
        if (old_ext == '0)
        begin
            w_ext = CW'(1);
        end
        else if (old_ext > MAX_W)
        begin
            w_ext = MAX_W;
        end
        else
        begin
            w_ext = old_ext;
        end
        n_ext = (new_ext == '0) ? CW'(1) : new_ext;
        if (n_ext > w_ext)
        begin
            n_ext = w_ext;
        end
        w = w_ext[WW-1:0];
        n = n_ext[WW-1:0];

        // A frame start restarts the row before the pixel is applied.
        for (int c = 0; c < 3; c++)
        begin
            pix[c]     = pix_data[c*PB +: PB];
            cur_sum[c] = pix_start ? '0 : sum_reg[c];
        end
        cur_units = pix_start ? w  : units_reg;
        cur_in    = pix_start ? '0 : in_col_reg;
        cur_out   = pix_start ? '0 : out_col_reg;
        cur_row   = pix_start ? '0 : row_reg;

        rem        = (cur_units == '0 || cur_units > w) ? w : cur_units;
        last       = (WW'(cur_in) >= (w - WW'(1)));
        accumulate = (n < rem) && !last;
        take       = (n < rem) ? n : rem;
        spill      = n - take;

        for (int c = 0; c < 3; c++)
        begin
            prod_n[c]     = PW'(pix[c]) * PW'(n);
            prod_take[c]  = PW'(pix[c]) * PW'(take);
            acc_sum[c]    = {1'b0, cur_sum[c]}
                          + {1'b0, (accumulate ? prod_n[c][SW-1:0] : prod_take[c][SW-1:0])};
            // A sum that no longer fits already averages to full scale.
            sat_sum[c]    = acc_sum[c][SW] ? '1 : acc_sum[c][SW-1:0];
            spill_prod[c] = prod_n[c][SW-1:0] - prod_take[c][SW-1:0];
        end

        pos_wide = {{aard_pkg::POS_BITS{1'b0}}, cur_out};
        row_wide = {{aard_pkg::SRC_ROW_BITS{1'b0}}, cur_row};
        job_data = {last,
                    row_wide[aard_pkg::SRC_ROW_BITS-1:0],
                    pos_wide[aard_pkg::POS_BITS-1:0],
                    w, sat_sum[2], sat_sum[1], sat_sum[0]};

        for (int c = 0; c < 3; c++)
        begin
            sum_next[c] = sum_reg[c];
        end
        units_next   = units_reg;
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        row_next     = row_reg;

        if (accept)
        begin
            if (accumulate)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sum_next[c] = sat_sum[c];
                end
                units_next   = rem - n;
                in_col_next  = cur_in + WIDTH_BITS'(1);
                out_col_next = cur_out;
                row_next     = cur_row;
            end
            else if (last)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sum_next[c] = '0;
                end
                units_next   = w;
                in_col_next  = '0;
                out_col_next = '0;
                row_next     = cur_row + ROW_BITS'(1);
            end
            else
            begin
                // The part of this pixel past the emitted output opens the next one.
                for (int c = 0; c < 3; c++)
                begin
                    sum_next[c] = spill_prod[c];
                end
                units_next   = w - spill;
                in_col_next  = cur_in + WIDTH_BITS'(1);
                out_col_next = cur_out + WIDTH_BITS'(1);
                row_next     = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= '0;
            end
            units_reg   <= WW'(1);
            in_col_reg  <= '0;
            out_col_reg <= '0;
            row_reg     <= '0;
        end
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
            units_reg   <= units_next;
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            row_reg     <= row_next;
        end
    end

endmodule

// ----- rtl/aard_back.sv -----
// ----------------------------------------------------------------------------
// aard_back
// Divides the three weighted sums of a job by the old width, rounding half
// up, one quotient bit per cycle, and holds the result for the output stream.
// ----------------------------------------------------------------------------
module aard_back #(
    parameter int WIDTH_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  job_valid,
    output logic                                  job_ready,
    input  logic [3*(WIDTH_BITS+8)+WIDTH_BITS+1+aard_pkg::POS_BITS+aard_pkg::SRC_ROW_BITS:0]
                                                  job_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [aard_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    output logic                                  m_tlast
);

    localparam int PB   = aard_pkg::PIX_BITS;
    localparam int WW   = WIDTH_BITS + 1;
    localparam int SW   = WIDTH_BITS + 8;
    localparam int RW   = WIDTH_BITS + 10;
    localparam int META = aard_pkg::POS_BITS + aard_pkg::SRC_ROW_BITS;
    localparam int PAD  = aard_pkg::OUT_DATA_BITS - 3*PB - META;
    localparam logic [3:0] LAST_STEP = 4'd8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [3:0]       step_reg, step_next;
    logic [RW-1:0]    rem_reg [3];
    logic [RW-1:0]    rem_next [3];
    logic [PB-1:0]    quo_reg [3];
    logic [PB-1:0]    quo_next [3];
    logic [2:0]       sat_reg, sat_next;
    logic [RW-1:0]    dsh_reg, dsh_next;
    logic [META-1:0]  meta_reg, meta_next;
    logic             last_reg, last_next;

    logic             out_valid_reg, out_valid_next;
    logic [3*PB+META-1:0] out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    logic [SW-1:0]    job_sum [3];
    logic [WW-1:0]    job_w;
    logic             ge [3];
    logic [PB-1:0]    avg [3];

    assign job_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{PAD{1'b0}}, out_data_reg};
    assign m_tlast   = out_last_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            job_sum[c] = job_data[c*SW +: SW];
        end
        job_w = job_data[3*SW +: WW];

        state_next     = state_reg;
        step_next      = step_reg;
        dsh_next       = dsh_reg;
        sat_next       = sat_reg;
        meta_next      = meta_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        for (int c = 0; c < 3; c++)
        begin
            rem_next[c] = rem_reg[c];
            quo_next[c] = quo_reg[c];
            ge[c]       = (rem_reg[c] >= dsh_reg);
            avg[c]      = sat_reg[c] ? '1 : quo_reg[c];
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    // Dividend 2*sum + w, first divisor 2*w shifted by eight.
                    for (int c = 0; c < 3; c++)
                    begin
                        rem_next[c] = RW'({job_sum[c], 1'b0}) + RW'(job_w);
                        quo_next[c] = '0;
                    end
                    dsh_next   = {job_w, 9'b0};
                    sat_next   = '0;
                    meta_next  = job_data[3*SW+WW +: META];
                    last_next  = job_data[3*SW+WW+META];
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // The first step only tests for a quotient past full scale.
                for (int c = 0; c < 3; c++)
                begin
                    if (step_reg == '0)
                    begin
                        sat_next[c] = ge[c];
                    end
                    else
                    begin
                        quo_next[c] = {quo_reg[c][PB-2:0], ge[c]};
                        if (ge[c])
                        begin
                            rem_next[c] = rem_reg[c] - dsh_reg;
                        end
                    end
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 4'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {meta_reg, avg[2], avg[1], avg[0]};
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            rem_reg[c] <= rem_next[c];
            quo_reg[c] <= quo_next[c];
        end
        sat_reg      <= sat_next;
        dsh_reg      <= dsh_next;
        meta_reg     <= meta_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= LAST_STEP))
        else $error("divider step counter out of range");

    a_run_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && step_reg == LAST_STEP) |=> (state_reg == ST_HOLD))
        else $error("divider did not finish after its last step");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && job_valid) |=> (state_reg == ST_RUN && step_reg == '0))
        else $error("job taken without starting the divider");

    a_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && !sat_reg[0]) |-> (rem_reg[0] < (dsh_reg << 1)))
        else $error("red remainder not below divisor");

endmodule

// ----- rtl/area_average_row_downscale.sv -----
// ----------------------------------------------------------------------------
// area_average_row_downscale
// Input: one pixel transfer per cycle while the two-entry job queue has room;
// every pixel waits while the queue is full. Output: for each averaged pixel
// the back end takes a job, runs 9 divider steps and loads the output
// register, and it takes no new job until that result is loaded. Reset
// clears the row state, sets both widths to 1 and empties the queue.
// ----------------------------------------------------------------------------
//
// Each source row of old_width pixels is cut into old_width*dst_width units.
// A source pixel covers dst_width units and an output pixel covers old_width
// units, so with dst_width clamped to old_width one source pixel touches at
// most two outputs. The front end keeps the weighted sums of the open output
// and, when a pixel closes it, pushes the sums with the divisor, the output
// position, the source row and the end-of-row flag into a short queue. The
// back end divides the three sums by old_width with round half up using a
// bit-serial restoring divider that keeps one remainder per component and
// shifts a single divisor for all three, and holds the result in an output
// register so a stalled sink does not stall the input until the queue fills.
//
// Configuration writes are always accepted and take effect from the next
// pixel. A frame start drops any partial row and restarts the row count.
module area_average_row_downscale #(
    parameter int WIDTH_BITS = 12,
    parameter int ROW_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Source pixels.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [aard_pkg::IN_DATA_BITS-1:0]     s_tdata,   // red, green, blue
    input  logic                                  s_tuser,   // frame_start

    // Averaged pixels.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [aard_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // out_red, out_green,
                                                             // out_blue, out_position,
                                                             // source_row, zero pad
    output logic                                  m_tlast,   // row_done

    // Register writes.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [aard_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [aard_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int JOB_BITS = 3*(WIDTH_BITS+8) + WIDTH_BITS + 1
                            + aard_pkg::POS_BITS + aard_pkg::SRC_ROW_BITS + 1;

    logic [aard_pkg::CFG_DATA_BITS-1:0] old_width_reg, old_width_next;
    logic [aard_pkg::CFG_DATA_BITS-1:0] dst_width_reg, dst_width_next;

    logic                push_valid, push_ready;
    logic [JOB_BITS-1:0] push_data;
    logic                pop_valid, pop_ready;
    logic [JOB_BITS-1:0] pop_data;

    // Register writes never stall.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        old_width_next = old_width_reg;
        dst_width_next = dst_width_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                aard_pkg::REG_OLD_WIDTH:
                begin
                    old_width_next = cfg_data;
                end
                aard_pkg::REG_NEW_WIDTH:
                begin
                    dst_width_next = cfg_data;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_width_reg <= aard_pkg::CFG_DATA_BITS'(1);
            dst_width_reg <= aard_pkg::CFG_DATA_BITS'(1);
        end
        else
        begin
            old_width_reg <= old_width_next;
            dst_width_reg <= dst_width_next;
        end
    end

    // Overlap accounting and accumulation; one pixel per cycle while the job queue has room.
    aard_front #(
        .WIDTH_BITS (WIDTH_BITS),
        .ROW_BITS   (ROW_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .old_width  (old_width_reg),
        .dst_width  (dst_width_reg),
        .pix_valid  (s_tvalid),
        .pix_ready  (s_tready),
        .pix_data   (s_tdata),
        .pix_start  (s_tuser),
        .job_valid  (push_valid),
        .job_ready  (push_ready),
        .job_data   (push_data)
    );

    // Decouples the front end from the divider.
    aard_queue #(
        .DATA_BITS  (JOB_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (push_valid),
        .in_ready   (push_ready),
        .in_data    (push_data),
        .out_valid  (pop_valid),
        .out_ready  (pop_ready),
        .out_data   (pop_data)
    );

    // Rounded division and output register.
    aard_back #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .job_data   (pop_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- verif/tb_area_average_row_downscale.sv -----
// ----------------------------------------------------------------------------
// tb_area_average_row_downscale
// Self-checking testbench for the area-averaging row downscaler. It drives
// RGB pixels with frame starts and width settings, predicts every averaged
// output in exact integer arithmetic, and checks each output transfer field
// by field.
// ----------------------------------------------------------------------------
module tb_area_average_row_downscale;

    import aard_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 11;
    localparam int TIMEOUT_CYCLES = 1000000;
    // Settling time after the last expected output; two queued jobs plus the
    // output register fit well within this.
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_PIXELS  = 2000;
    localparam int MAX_COLUMNS    = 1 << POS_BITS;

    // Bit positions of the output fields inside m_tdata.
    localparam int GREEN_LSB = PIX_BITS;
    localparam int BLUE_LSB  = 2 * PIX_BITS;
    localparam int POS_LSB   = 3 * PIX_BITS;
    localparam int ROW_LSB   = POS_LSB + POS_BITS;

    // One averaged pixel as it should leave the block.
    typedef struct packed {
        logic [PIX_BITS-1:0]     out_red;
        logic [PIX_BITS-1:0]     out_green;
        logic [PIX_BITS-1:0]     out_blue;
        logic [POS_BITS-1:0]     out_position;
        logic [SRC_ROW_BITS-1:0] source_row;
        logic                    row_done;
    } scaled_pixel_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the width registers and the row state,
    // predicts the output that each accepted pixel completes, and compares
    // output transfers against the oldest prediction.
    // ------------------------------------------------------------------------
    class downscale_scoreboard;
        logic [CFG_DATA_BITS-1:0] old_width_reg;
        logic [CFG_DATA_BITS-1:0] dst_width_reg;
        longint unsigned          acc_red;
        longint unsigned          acc_green;
        longint unsigned          acc_blue;
        int unsigned              units_left;
        logic [POS_BITS-1:0]      in_col;
        logic [POS_BITS-1:0]      out_col;
        logic [SRC_ROW_BITS-1:0]  row_idx;
        scaled_pixel_t            expected_q[$];
        int unsigned              mismatches;

        function new();
            old_width_reg = 1;
            dst_width_reg = 1;
            row_idx       = '0;
            mismatches    = 0;
            restart_row(1);
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] val);
            if (idx == REG_OLD_WIDTH)
                old_width_reg = val;
            else
                dst_width_reg = val;
        endfunction

        function void restart_row(int unsigned w);
            acc_red    = 0;
            acc_green  = 0;
            acc_blue   = 0;
            units_left = w;
            in_col     = '0;
            out_col    = '0;
        endfunction

        // Divide by the source width with round half up, saturating at 255.
        function logic [PIX_BITS-1:0] round_avg(longint unsigned s, int unsigned w);
            longint unsigned wl;
            longint unsigned q;
            wl = w;
            q  = (2 * s + wl) / (2 * wl);
            return (q > 255) ? 8'd255 : q[PIX_BITS-1:0];
        endfunction

        function void note_pixel(logic [PIX_BITS-1:0] r, logic [PIX_BITS-1:0] g,
                                 logic [PIX_BITS-1:0] b, logic frame_start);
            int unsigned   w;
            int unsigned   n;
            int unsigned   rem;
            int unsigned   take;
            int unsigned   spill;
            logic          row_end;
            scaled_pixel_t res;

            w = (old_width_reg == 0) ? 1 : old_width_reg;
            if (w > MAX_COLUMNS)
                w = MAX_COLUMNS;
            n = (dst_width_reg == 0) ? 1 : dst_width_reg;
            if (n > w)
                n = w;

            if (frame_start)
            begin
                restart_row(w);
                row_idx = '0;
            end

            // A stale remainder (after a width change) opens a fresh output.
            rem = units_left;
            if (rem == 0 || rem > w)
                rem = w;
            row_end = (in_col >= w - 1);

            if (n < rem && !row_end)
            begin
                acc_red    += r * n;
                acc_green  += g * n;
                acc_blue   += b * n;
                units_left  = rem - n;
                in_col      = in_col + 1'b1;
                return;
            end

            take = (n < rem) ? n : rem;
            res.out_red      = round_avg(acc_red + r * take, w);
            res.out_green    = round_avg(acc_green + g * take, w);
            res.out_blue     = round_avg(acc_blue + b * take, w);
            res.out_position = out_col;
            res.source_row   = row_idx;
            res.row_done     = row_end;
            expected_q.push_back(res);

            if (row_end)
            begin
                restart_row(w);
                row_idx = row_idx + 1'b1;
            end
            else
            begin
                // The part of this pixel past the closed output opens the next.
                spill      = n - take;
                acc_red    = r * spill;
                acc_green  = g * spill;
                acc_blue   = b * spill;
                units_left = w - spill;
                out_col    = out_col + 1'b1;
                in_col     = in_col + 1'b1;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_output(logic [OUT_DATA_BITS-1:0] data, logic last);
            scaled_pixel_t want;
            if (expected_q.size() == 0)
            begin
                $error("output transfer with nothing expected: tdata=%h tlast=%b",
                       data, last);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_red", want.out_red, data[PIX_BITS-1:0]);
            compare_field("out_green", want.out_green, data[GREEN_LSB +: PIX_BITS]);
            compare_field("out_blue", want.out_blue, data[BLUE_LSB +: PIX_BITS]);
            compare_field("out_position", want.out_position, data[POS_LSB +: POS_BITS]);
            compare_field("source_row", want.source_row, data[ROW_LSB +: SRC_ROW_BITS]);
            compare_field("row_done", want.row_done, last);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test.
    // ------------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata;   // red, green, blue
    logic                      s_tuser;   // frame_start
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_DATA_BITS-1:0]  m_tdata;   // out_red, out_green, out_blue,
                                          // out_position, source_row, zero pad
    logic                      m_tlast;   // row_done
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    area_average_row_downscale DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    downscale_scoreboard board;

    // Idle percentages for the current phase, and the length of a forced
    // receiver hold-off. The stimulus process sets them; the output process
    // counts the hold-off down.
    int unsigned src_gap_pct    = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned sink_hold      = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Reset is applied once, at the start of the run.
    initial
    begin
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard limit on the run: a hang in either handshake ends up here.
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("** area_average_row_downscale: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: checks every output transfer and decides tready for the
    // next cycle, either from the stall percentage or from a forced hold-off.
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_output(m_tdata, m_tlast);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                sink_hold--;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. All of them are entered just after a rising edge and
    // leave just after the edge at which their last transfer took place.
    // ------------------------------------------------------------------------

    // Offers one pixel after a random number of idle cycles and waits for its
    // transfer. tvalid is left high so back-to-back pixels need no gap.
    task automatic send_pixel(input logic [PIX_BITS-1:0] r, input logic [PIX_BITS-1:0] g,
                              input logic [PIX_BITS-1:0] b, input logic frame_start);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        s_tuser  <= frame_start;
        do @(posedge clk); while (!s_tready);
        board.note_pixel(r, g, b, frame_start);
    endtask

    // Drops tvalid and waits until every predicted output has been seen, then
    // lets the back end settle, since pixels that close no output may still
    // be in flight behind the last one that did.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, val);
    endtask

    // Width changes only happen with the block idle; the row position is
    // kept, so a change can still land in the middle of a source row.
    task automatic configure(input logic [CFG_DATA_BITS-1:0] old_w,
                             input logic [CFG_DATA_BITS-1:0] new_w);
        wait_idle();
        if ($urandom_range(1))
        begin
            write_register(REG_OLD_WIDTH, old_w);
            write_register(REG_NEW_WIDTH, new_w);
        end
        else
        begin
            write_register(REG_NEW_WIDTH, new_w);
            write_register(REG_OLD_WIDTH, old_w);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly uniform levels, with the two extremes made more likely.
    function automatic logic [PIX_BITS-1:0] pick_level();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 8'd255 : 8'd0;
        return $urandom_range(255);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned              phase;
        int unsigned              sent;
        int unsigned              count;
        int unsigned              col;
        int unsigned              eff_width;
        logic [CFG_DATA_BITS-1:0] old_w;
        logic [CFG_DATA_BITS-1:0] new_w;
        logic                     frame_start;
        logic                     fresh_frame;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        board = new();

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed part, with no idling on either side.

        // Widths of one: every pixel is a whole row and its own output.
        configure(1, 1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);

        // Three to two: the middle pixel is split across both outputs, which
        // exercises the rounding.
        configure(3, 2);
        send_pixel(8'd255, 8'd0, 8'd128, 1'b1);
        send_pixel(8'd1, 8'd254, 8'd127, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0);

        // Enlargement request: the new width is clamped to the old one.
        configure(2, 5);
        send_pixel(8'd10, 8'd20, 8'd30, 1'b1);
        send_pixel(8'd200, 8'd100, 8'd0, 1'b0);

        // Zero widths behave as one.
        configure(0, 0);
        send_pixel(8'd77, 8'd88, 8'd99, 1'b1);

        // All-ones old width saturates to the largest row; a few pixels of it,
        // then the row is cut short by shrinking the old width mid row, which
        // also leaves a remainder larger than the new old width.
        configure(13'h1FFF, 13'd4096);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd128, 8'd64, 8'd32, 1'b0);
        configure(2, 1);
        send_pixel(8'd9, 8'd9, 8'd9, 1'b0);

        // Sums built for a wide output and then divided by a width of one:
        // the average saturates at full scale.
        configure(4, 1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        configure(1, 1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);

        // Frame start in the middle of a row drops the partial row.
        configure(5, 2);
        send_pixel(8'd50, 8'd60, 8'd70, 1'b1);
        send_pixel(8'd80, 8'd90, 8'd100, 1'b0);
        send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
        send_pixel(8'd4, 8'd5, 8'd6, 1'b0);
        send_pixel(8'd7, 8'd8, 8'd9, 1'b0);
        send_pixel(8'd10, 8'd11, 8'd12, 1'b0);
        send_pixel(8'd13, 8'd14, 8'd15, 1'b0);

        // Random part: phases of one width setting each, cycling through the
        // idling modes. Most phases send frames of small rows; now and
        // then a wide row is sent in part, so the next setting lands mid row.
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_PIXELS)
        begin
            case (phase % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 76; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 76; end
                default: begin src_gap_pct = 27; sink_stall_pct = 27; end
            endcase

            if (phase == 4)
            begin
                // Every pixel closes an output, so a long receiver hold-off
                // fills the job queue and stalls the input side.
                old_w = $urandom_range(1, 3);
                new_w = old_w;
            end
            else if ($urandom_range(9) == 0)
            begin
                old_w = $urandom_range(64, 8191);
                new_w = $urandom_range(1, 8191);
            end
            else
            begin
                old_w = $urandom_range(1, 12);
                new_w = $urandom_range(0, old_w + 2);
            end
            configure(old_w, new_w);
            if (phase == 4)
            begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
                sink_hold      = 400;
            end

            eff_width   = (old_w > MAX_COLUMNS) ? MAX_COLUMNS : old_w;
            count       = $urandom_range(30, 120);
            fresh_frame = ($urandom_range(3) != 0);
            col         = 0;
            for (int unsigned k = 0; k < count; k++)
            begin
                frame_start = (k == 0 && fresh_frame)
                              || (col == 0 && $urandom_range(19) == 0)
                              || ($urandom_range(99) == 0);
                if (frame_start)
                    col = 0;
                send_pixel(pick_level(), pick_level(), pick_level(), frame_start);
                col++;
                if (col >= eff_width)
                    col = 0;
            end
            sent += count;
            phase++;
        end

        wait_idle();
        if (board.mismatches == 0)
            $display("** area_average_row_downscale: PASSED **");
        else
            $display("** area_average_row_downscale: FAILED **");
        $finish;
    end

endmodule
